// ----- rtl/core/psipc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psipc_pkg: shared types and constants of the per-source IPv4 packet counter
// Payload structs, table entry layout, controller command and status groups.
// ----------------------------------------------------------------------------
package psipc_pkg;

    localparam logic [15:0] ETH_HEADER_BYTES = 16'd14;
    localparam logic [15:0] IPV4_MIN_BYTES   = 16'd34;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;

    localparam logic VERDICT_PASS  = 1'b0;
    localparam logic VERDICT_ABORT = 1'b1;

    localparam logic [1:0] COUNTED_NONE = 2'd0;
    localparam logic [1:0] COUNTED_YES  = 2'd1;
    localparam logic [1:0] COUNTED_FULL = 2'd2;

    // Classification of an incoming item
    localparam logic [1:0] CLASS_ABORT  = 2'd0;
    localparam logic [1:0] CLASS_PASS   = 2'd1;
    localparam logic [1:0] CLASS_LOOKUP = 2'd2;

    // Result selection for the output register
    localparam logic [2:0] OUT_ABORT  = 3'd0;
    localparam logic [2:0] OUT_PASS   = 3'd1;
    localparam logic [2:0] OUT_HIT    = 3'd2;
    localparam logic [2:0] OUT_INSERT = 3'd3;
    localparam logic [2:0] OUT_FULL   = 3'd4;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] source_address;
    } psipc_in_t;

    typedef struct packed {
        logic        verdict;
        logic [1:0]  counted;
        logic [63:0] packet_count;
    } psipc_out_t;

    typedef struct packed {
        logic        occupied;
        logic [31:0] key;
        logic [63:0] count;
    } psipc_entry_t;

    typedef struct packed {
        logic       clear_step;
        logic       load_item;
        logic       read_issue;
        logic       probe_next;
        logic       write_hit;
        logic       write_insert;
        logic       out_load;
        logic [2:0] out_sel;
    } psipc_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] item_class;
        logic       hit;
        logic       empty_slot;
        logic       probe_last;
        logic       out_busy;
    } psipc_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/psipc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psipc_ctrl: sequencer of the per-source IPv4 packet counter
// Runs the table clearing pass, takes items and steps the hash probe loop.
// ----------------------------------------------------------------------------
module psipc_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  psipc_pkg::psipc_status_t status,
    output psipc_pkg::psipc_cmd_t    cmd
);
    import psipc_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !status.out_busy;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_PASS;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    case (status.item_class)
                        CLASS_ABORT: begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ABORT;
                        end
                        CLASS_LOOKUP: begin
                            cmd.load_item = 1'b1;
                            state_next    = ST_READ;
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_PASS;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.read_issue = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK: begin
                // hold the probe result until the output register is free
                if (!status.out_busy) begin
                    if (status.hit) begin
                        cmd.write_hit = 1'b1;
                        cmd.out_load  = 1'b1;
                        cmd.out_sel   = OUT_HIT;
                        state_next    = ST_IDLE;
                    end else if (status.empty_slot) begin
                        cmd.write_insert = 1'b1;
                        cmd.out_load     = 1'b1;
                        cmd.out_sel      = OUT_INSERT;
                        state_next       = ST_IDLE;
                    end else if (status.probe_last) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_FULL;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.probe_next = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/psipc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psipc_datapath: table memory, probe address, key and result registers
// Open-addressed hash table with linear probing over CAPACITY slots.
// ----------------------------------------------------------------------------
module psipc_datapath #(
    parameter int CAPACITY = 1024
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  psipc_pkg::psipc_cmd_t    cmd,
    output psipc_pkg::psipc_status_t status,
    input  psipc_pkg::psipc_in_t     s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output psipc_pkg::psipc_out_t    m_data
);
    import psipc_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);

    psipc_entry_t     table_mem [CAPACITY];
    psipc_entry_t     rd_reg;
    psipc_entry_t     wr_data;
    logic             wr_en;

    logic [IDX_W-1:0] probe_addr_reg;
    logic [IDX_W-1:0] probe_addr_next;
    logic [IDX_W-1:0] probe_cnt_reg;
    logic [IDX_W-1:0] probe_cnt_next;
    logic [31:0]      key_reg;
    logic [IDX_W-1:0] hash_fold;
    logic [IDX_W:0]   hash_diff;
    logic [IDX_W-1:0] home_idx;
    logic [IDX_W-1:0] step_idx;
    logic [63:0]      count_inc;

    logic             m_valid_reg;
    logic             m_valid_next;
    psipc_out_t       m_data_reg;
    psipc_out_t       m_data_next;

    // fold the key into the index width, then bring it into range
    always_comb begin
        hash_fold = '0;
        for (int b = 0; b < 32; b++) begin
            hash_fold[b % IDX_W] = hash_fold[b % IDX_W] ^ s_data.source_address[b];
        end
        hash_diff = {1'b0, hash_fold} - CAP_EXT;
        home_idx  = ({1'b0, hash_fold} >= CAP_EXT) ? hash_diff[IDX_W-1:0] : hash_fold;
    end

    assign step_idx  = (probe_addr_reg == LAST_IDX) ? '0 : probe_addr_reg + 1'b1;
    assign count_inc = rd_reg.count + 64'd1;

    always_comb begin
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        if (cmd.clear_step || cmd.probe_next) begin
            probe_addr_next = step_idx;
        end else if (cmd.load_item) begin
            probe_addr_next = home_idx;
        end
        if (cmd.load_item) begin
            probe_cnt_next = '0;
        end else if (cmd.probe_next) begin
            probe_cnt_next = probe_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_addr_reg <= '0;
            probe_cnt_reg  <= '0;
        end else begin
            probe_addr_reg <= probe_addr_next;
            probe_cnt_reg  <= probe_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            key_reg <= s_data.source_address;
        end
    end

    // table memory: one write port, one registered read port
    assign wr_en = cmd.clear_step || cmd.write_hit || cmd.write_insert;

    always_comb begin
        wr_data = '0;
        if (cmd.write_hit) begin
            wr_data = '{occupied: 1'b1, key: key_reg, count: count_inc};
        end else if (cmd.write_insert) begin
            wr_data = '{occupied: 1'b1, key: key_reg, count: 64'd1};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[probe_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_issue) begin
            rd_reg <= table_mem[probe_addr_reg];
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            case (cmd.out_sel)
                OUT_ABORT:  m_data_next = '{VERDICT_ABORT, COUNTED_NONE, 64'd0};
                OUT_HIT:    m_data_next = '{VERDICT_PASS, COUNTED_YES, count_inc};
                OUT_INSERT: m_data_next = '{VERDICT_PASS, COUNTED_YES, 64'd1};
                OUT_FULL:   m_data_next = '{VERDICT_PASS, COUNTED_FULL, 64'd0};
                default:    m_data_next = '{VERDICT_PASS, COUNTED_NONE, 64'd0};
            endcase
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        status            = '0;
        status.clear_last = (probe_addr_reg == LAST_IDX);
        if (s_data.frame_length < ETH_HEADER_BYTES) begin
            status.item_class = CLASS_ABORT;
        end else if (s_data.ether_type != ETHERTYPE_IPV4) begin
            status.item_class = CLASS_PASS;
        end else if (s_data.frame_length < IPV4_MIN_BYTES) begin
            status.item_class = CLASS_ABORT;
        end else begin
            status.item_class = CLASS_LOOKUP;
        end
        status.hit        = rd_reg.occupied && (rd_reg.key == key_reg);
        status.empty_slot = !rd_reg.occupied;
        status.probe_last = (probe_cnt_reg == LAST_IDX);
        status.out_busy   = m_valid_reg && !m_ready;
    end

endmodule
`default_nettype wire

// ----- rtl/core/per_source_ipv4_packet_counter_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_ipv4_packet_counter_core: packet counts per IPv4 source address
// Classifies frame summaries and keeps a wrapping 64-bit count per source.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                                   | handshake
//  s_       | in        | frame_length, ether_type, source_address  | s_valid/s_ready
//  m_       | out       | verdict, counted, packet_count            | m_valid/m_ready
//
// After reset the table is cleared one slot a cycle, with s_ready low until
// the last slot is cleared. Aborted and non-IPv4 items are answered from
// idle without a table lookup. A lookup probes hash slots in turn, one
// memory read and one compare per slot, up to CAPACITY slots on a full table.
// One item is worked on at a time; a waiting result holds the block in place.
// ----------------------------------------------------------------------------
module per_source_ipv4_packet_counter_core #(
    parameter int CAPACITY = 1024
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  psipc_pkg::psipc_in_t  s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output psipc_pkg::psipc_out_t m_data
);
    import psipc_pkg::*;

    psipc_cmd_t    cmd;
    psipc_status_t status;

    psipc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    psipc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- rtl/core/psipc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psipc_checker: port-level checks of the packet counter core
// Result hold, result field consistency and the short abort and non-IPv4 paths.
// ----------------------------------------------------------------------------
module psipc_checker (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_valid,
    input wire                   s_ready,
    input psipc_pkg::psipc_in_t  s_data,
    input wire                   m_valid,
    input wire                   m_ready,
    input psipc_pkg::psipc_out_t m_data
);
    import psipc_pkg::*;

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_uncounted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.counted != COUNTED_YES) |-> (m_data.packet_count == 64'd0))
        else $error("uncounted result carries a count");

    a_abort_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.verdict == VERDICT_ABORT) |-> (m_data.counted == COUNTED_NONE))
        else $error("aborted frame reported as counted");

    a_short_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.frame_length < ETH_HEADER_BYTES)
        |=> m_valid && (m_data.verdict == VERDICT_ABORT))
        else $error("short frame not aborted in one cycle");

    a_non_ipv4_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.frame_length >= ETH_HEADER_BYTES)
        && (s_data.ether_type != ETHERTYPE_IPV4)
        |=> m_valid && (m_data.verdict == VERDICT_PASS) && (m_data.counted == COUNTED_NONE))
        else $error("non-IPv4 frame not passed uncounted");

endmodule

bind per_source_ipv4_packet_counter_core psipc_checker u_psipc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
